FILE: rtl/hrp_pkg.sv
// Shared types, character constants and result codes for the response head parser.
`default_nettype none

package hrp_pkg;

    typedef enum logic [15:0] {
        PH_LIT    = 16'h0001,
        PH_MAJOR  = 16'h0002,
        PH_DOT    = 16'h0004,
        PH_MINOR  = 16'h0008,
        PH_SP1    = 16'h0010,
        PH_CODE   = 16'h0020,
        PH_SP2    = 16'h0040,
        PH_REASON = 16'h0080,
        PH_LINE   = 16'h0100,
        PH_NAME   = 16'h0200,
        PH_OWS    = 16'h0400,
        PH_VALUE  = 16'h0800,
        PH_HDR_LF = 16'h1000,
        PH_END_LF = 16'h2000,
        PH_BODY   = 16'h4000,
        PH_ERROR  = 16'h8000
    } t_phase;

    localparam logic [2:0] ROLE_SYNTAX  = 3'd0;
    localparam logic [2:0] ROLE_REASON  = 3'd1;
    localparam logic [2:0] ROLE_NAME    = 3'd2;
    localparam logic [2:0] ROLE_VALUE   = 3'd3;
    localparam logic [2:0] ROLE_BODY    = 3'd4;
    localparam logic [2:0] ROLE_IGNORED = 3'd5;

    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_BAD_BYTE  = 2'd1;
    localparam logic [1:0] ERR_TRUNCATED = 2'd2;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [2:0] LIT_LEN  = 3'd5;
    localparam logic [1:0] CODE_LEN = 2'd3;

    // Control part of the parse state; the length counters travel separately.
    typedef struct packed {
        t_phase     phase;
        logic [2:0] lit_idx;
        logic [9:0] code;
        logic [3:0] major;
        logic [3:0] minor;
        logic [1:0] error;
    } t_ctrl;

    localparam t_ctrl CTRL_RESET = '{
        phase:   PH_LIT,
        lit_idx: 3'd0,
        code:    10'd0,
        major:   4'd0,
        minor:   4'd0,
        error:   ERR_NONE
    };

    typedef struct packed {
        logic [2:0]  role;
        logic [1:0]  error;
        logic        status_done;
        logic [3:0]  major;
        logic [3:0]  minor;
        logic [9:0]  code;
        logic [15:0] reason_len;
        logic        header_done;
        logic [15:0] name_len;
        logic [15:0] value_len;
        logic        headers_end;
    } t_result;

    function automatic logic [7:0] proto_char(input logic [2:0] idx);
        logic [7:0] ch;
        case (idx)
            3'd0:    ch = 8'h48;
            3'd1:    ch = 8'h54;
            3'd2:    ch = 8'h54;
            3'd3:    ch = 8'h50;
            3'd4:    ch = 8'h2F;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/http_response_head_parser.sv
// Top level of the response head parser: input register, parse state and result register.
//
//   Channel  Handshake                 Payload
//   in       i_in_valid / o_in_ready   i_data_byte, i_first_byte, i_last_byte
//   out      o_out_valid / i_out_ready o_byte_role ... o_headers_end (one result per item)
//
// One item is taken every cycle unless the output stalls; each item is first held in the
// input register and its result then in the result register. The parse step sits between
// the two, and the parse state is updated when an item moves from one to the other.
// Reset puts the parser at the start of a status line and empties both registers.
// When the output is stalled the result holds, one more item waits in the input register,
// and the input then stalls until the result is taken.
`default_nettype none

module http_response_head_parser #(
    parameter int LENGTH_BITS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_first_byte,
    input  wire logic        i_last_byte,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [2:0]       o_byte_role,
    output logic [1:0]       o_error_code,
    output logic             o_status_done,
    output logic [3:0]       o_ver_major,
    output logic [3:0]       o_ver_minor,
    output logic [9:0]       o_resp_code,
    output logic [15:0]      o_reason_length,
    output logic             o_header_done,
    output logic [15:0]      o_name_length,
    output logic [15:0]      o_value_length,
    output logic             o_headers_end
);

    logic                    r_in_valid;
    logic [7:0]              r_in_byte;
    logic                    r_in_first;
    logic                    r_in_last;
    hrp_pkg::t_ctrl          r_ctrl;
    logic [LENGTH_BITS-1:0]  r_field_cnt;
    logic [LENGTH_BITS-1:0]  r_value_cnt;
    logic [LENGTH_BITS-1:0]  r_trim_end;
    logic                    r_out_valid;
    hrp_pkg::t_result        r_out;

    hrp_pkg::t_ctrl          n_ctrl;
    logic [LENGTH_BITS-1:0]  n_field_cnt;
    logic [LENGTH_BITS-1:0]  n_value_cnt;
    logic [LENGTH_BITS-1:0]  n_trim_end;
    hrp_pkg::t_result        n_out;

    logic                    advance;
    logic                    in_take;

    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;
    assign in_take    = i_in_valid && o_in_ready;

    hrp_step #(
        .LENGTH_BITS(LENGTH_BITS)
    ) u_step (
        .i_byte      (r_in_byte),
        .i_first     (r_in_first),
        .i_last      (r_in_last),
        .i_ctrl      (r_ctrl),
        .i_field_cnt (r_field_cnt),
        .i_value_cnt (r_value_cnt),
        .i_trim_end  (r_trim_end),
        .o_ctrl      (n_ctrl),
        .o_field_cnt (n_field_cnt),
        .o_value_cnt (n_value_cnt),
        .o_trim_end  (n_trim_end),
        .o_result    (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_ctrl      <= hrp_pkg::CTRL_RESET;
            r_field_cnt <= '0;
            r_value_cnt <= '0;
            r_trim_end  <= '0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_ctrl      <= n_ctrl;
                r_field_cnt <= n_field_cnt;
                r_value_cnt <= n_value_cnt;
                r_trim_end  <= n_trim_end;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte  <= i_data_byte;
            r_in_first <= i_first_byte;
            r_in_last  <= i_last_byte;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_byte_role     = r_out.role;
    assign o_error_code    = r_out.error;
    assign o_status_done   = r_out.status_done;
    assign o_ver_major     = r_out.major;
    assign o_ver_minor     = r_out.minor;
    assign o_resp_code     = r_out.code;
    assign o_reason_length = r_out.reason_len;
    assign o_header_done   = r_out.header_done;
    assign o_name_length   = r_out.name_len;
    assign o_value_length  = r_out.value_len;
    assign o_headers_end   = r_out.headers_end;

endmodule

`default_nettype wire

FILE: rtl/hrp_step.sv
// Next-state and result logic for one byte of the response head parser.
`default_nettype none

module hrp_step #(
    parameter int LENGTH_BITS = 16
) (
    input  wire logic [7:0]             i_byte,
    input  wire logic                   i_first,
    input  wire logic                   i_last,
    input  wire hrp_pkg::t_ctrl         i_ctrl,
    input  wire logic [LENGTH_BITS-1:0] i_field_cnt,
    input  wire logic [LENGTH_BITS-1:0] i_value_cnt,
    input  wire logic [LENGTH_BITS-1:0] i_trim_end,
    output hrp_pkg::t_ctrl              o_ctrl,
    output logic [LENGTH_BITS-1:0]      o_field_cnt,
    output logic [LENGTH_BITS-1:0]      o_value_cnt,
    output logic [LENGTH_BITS-1:0]      o_trim_end,
    output hrp_pkg::t_result            o_result
);

    localparam logic [LENGTH_BITS-1:0] CNT_MAX = '1;

    hrp_pkg::t_ctrl          cur;
    hrp_pkg::t_ctrl          nxt;
    logic [LENGTH_BITS-1:0]  fc;
    logic [LENGTH_BITS-1:0]  vc;
    logic [LENGTH_BITS-1:0]  te;
    logic [LENGTH_BITS-1:0]  n_fc;
    logic [LENGTH_BITS-1:0]  n_vc;
    logic [LENGTH_BITS-1:0]  n_te;
    logic [LENGTH_BITS-1:0]  fc_inc;
    logic [LENGTH_BITS-1:0]  vc_inc;
    logic [LENGTH_BITS-1:0]  fc_dec;
    logic                    is_digit;
    logic                    is_ows;
    logic                    bad;
    logic [13:0]             code_next;
    hrp_pkg::t_result        res;

    function automatic logic [15:0] clip16(input logic [31:0] v);
        return (v > 32'h0000_FFFF) ? 16'hFFFF : v[15:0];
    endfunction

    always_comb begin
        cur = i_first ? hrp_pkg::CTRL_RESET : i_ctrl;
        fc  = i_first ? '0 : i_field_cnt;
        vc  = i_first ? '0 : i_value_cnt;
        te  = i_first ? '0 : i_trim_end;

        fc_inc = (fc == CNT_MAX) ? fc : fc + LENGTH_BITS'(1);
        vc_inc = (vc == CNT_MAX) ? vc : vc + LENGTH_BITS'(1);
        fc_dec = fc - LENGTH_BITS'(1);

        is_digit = i_byte inside {[hrp_pkg::CH_ZERO:hrp_pkg::CH_NINE]};
        is_ows   = (i_byte == hrp_pkg::CH_SPACE) || (i_byte == hrp_pkg::CH_TAB);
        code_next = ({4'b0, cur.code} << 3) + ({4'b0, cur.code} << 1) + {10'b0, i_byte[3:0]};

        nxt  = cur;
        n_fc = fc;
        n_vc = vc;
        n_te = te;
        bad  = 1'b0;
        res  = '0;
        res.role = hrp_pkg::ROLE_SYNTAX;

        case (cur.phase)
            hrp_pkg::PH_LIT: begin
                if (cur.lit_idx < hrp_pkg::LIT_LEN &&
                    i_byte == hrp_pkg::proto_char(cur.lit_idx)) begin
                    if (cur.lit_idx == hrp_pkg::LIT_LEN - 3'd1) begin
                        nxt.phase   = hrp_pkg::PH_MAJOR;
                        nxt.lit_idx = 3'd0;
                    end else begin
                        nxt.lit_idx = cur.lit_idx + 3'd1;
                    end
                end else begin
                    bad = 1'b1;
                end
            end
            hrp_pkg::PH_MAJOR: begin
                if (is_digit) begin
                    nxt.major = i_byte[3:0];
                    nxt.phase = hrp_pkg::PH_DOT;
                end else begin
                    bad = 1'b1;
                end
            end
            hrp_pkg::PH_DOT: begin
                if (i_byte == hrp_pkg::CH_DOT) begin
                    nxt.phase = hrp_pkg::PH_MINOR;
                end else begin
                    bad = 1'b1;
                end
            end
            hrp_pkg::PH_MINOR: begin
                if (is_digit) begin
                    nxt.minor = i_byte[3:0];
                    nxt.phase = hrp_pkg::PH_SP1;
                end else begin
                    bad = 1'b1;
                end
            end
            hrp_pkg::PH_SP1: begin
                if (i_byte == hrp_pkg::CH_SPACE) begin
                    nxt.phase   = hrp_pkg::PH_CODE;
                    nxt.lit_idx = 3'd0;
                    nxt.code    = 10'd0;
                end else begin
                    bad = 1'b1;
                end
            end
            hrp_pkg::PH_CODE: begin
                if (is_digit) begin
                    nxt.code = code_next[9:0];
                    if (cur.lit_idx >= {1'b0, hrp_pkg::CODE_LEN} - 3'd1) begin
                        nxt.phase   = hrp_pkg::PH_SP2;
                        nxt.lit_idx = 3'd0;
                    end else begin
                        nxt.lit_idx = cur.lit_idx + 3'd1;
                    end
                end else begin
                    bad = 1'b1;
                end
            end
            hrp_pkg::PH_SP2: begin
                if (i_byte == hrp_pkg::CH_SPACE) begin
                    nxt.phase = hrp_pkg::PH_REASON;
                    n_fc      = '0;
                end else begin
                    bad = 1'b1;
                end
            end
            hrp_pkg::PH_REASON: begin
                if (i_byte == hrp_pkg::CH_LF) begin
                    res.status_done = 1'b1;
                    res.reason_len  = (fc == '0) ? 16'd0 : clip16(32'(fc_dec));
                    nxt.phase       = hrp_pkg::PH_LINE;
                end else begin
                    res.role = hrp_pkg::ROLE_REASON;
                    n_fc     = fc_inc;
                end
            end
            hrp_pkg::PH_LINE: begin
                n_fc = '0;
                n_vc = '0;
                n_te = '0;
                if (i_byte == hrp_pkg::CH_CR) begin
                    nxt.phase = hrp_pkg::PH_END_LF;
                end else if (i_byte == hrp_pkg::CH_COLON) begin
                    nxt.phase = hrp_pkg::PH_OWS;
                end else begin
                    res.role  = hrp_pkg::ROLE_NAME;
                    n_fc      = LENGTH_BITS'(1);
                    nxt.phase = hrp_pkg::PH_NAME;
                end
            end
            hrp_pkg::PH_NAME: begin
                if (i_byte == hrp_pkg::CH_COLON) begin
                    nxt.phase = hrp_pkg::PH_OWS;
                end else begin
                    res.role = hrp_pkg::ROLE_NAME;
                    n_fc     = fc_inc;
                end
            end
            hrp_pkg::PH_OWS, hrp_pkg::PH_VALUE: begin
                if (i_byte == hrp_pkg::CH_CR) begin
                    nxt.phase = hrp_pkg::PH_HDR_LF;
                end else if (is_ows) begin
                    if (cur.phase == hrp_pkg::PH_VALUE) begin
                        res.role = hrp_pkg::ROLE_VALUE;
                        n_vc     = vc_inc;
                    end
                end else if (i_byte < hrp_pkg::CH_SPACE) begin
                    bad = 1'b1;
                end else begin
                    res.role  = hrp_pkg::ROLE_VALUE;
                    n_vc      = vc_inc;
                    n_te      = vc_inc;
                    nxt.phase = hrp_pkg::PH_VALUE;
                end
            end
            hrp_pkg::PH_HDR_LF: begin
                if (i_byte == hrp_pkg::CH_LF) begin
                    res.header_done = 1'b1;
                    res.name_len    = clip16(32'(fc));
                    res.value_len   = clip16(32'(te));
                    nxt.phase       = hrp_pkg::PH_LINE;
                end else begin
                    bad = 1'b1;
                end
            end
            hrp_pkg::PH_END_LF: begin
                if (i_byte == hrp_pkg::CH_LF) begin
                    res.headers_end = 1'b1;
                    nxt.phase       = hrp_pkg::PH_BODY;
                end else begin
                    bad = 1'b1;
                end
            end
            hrp_pkg::PH_BODY: begin
                res.role = hrp_pkg::ROLE_BODY;
            end
            hrp_pkg::PH_ERROR: begin
                res.role = hrp_pkg::ROLE_IGNORED;
            end
            default: begin
                res.role = hrp_pkg::ROLE_IGNORED;
            end
        endcase

        if (bad) begin
            nxt.error = hrp_pkg::ERR_BAD_BYTE;
            nxt.phase = hrp_pkg::PH_ERROR;
            res.role  = hrp_pkg::ROLE_IGNORED;
        end
        if (i_last && nxt.phase != hrp_pkg::PH_BODY && nxt.phase != hrp_pkg::PH_ERROR) begin
            nxt.error = hrp_pkg::ERR_TRUNCATED;
            nxt.phase = hrp_pkg::PH_ERROR;
        end

        res.error = nxt.error;
        res.major = nxt.major;
        res.minor = nxt.minor;
        res.code  = nxt.code;
    end

    assign o_ctrl      = nxt;
    assign o_field_cnt = n_fc;
    assign o_value_cnt = n_vc;
    assign o_trim_end  = n_te;
    assign o_result    = res;

endmodule

`default_nettype wire

FILE: sim/http_response_head_parser_tb.sv
// Self-checking testbench for the HTTP response head parser with a byte-level predictor.
`timescale 1ns / 100ps

module http_response_head_parser_tb;

    localparam logic [39:0] PROTO_TEXT = "HTTP/";

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic [7:0]  i_data_byte = 8'h00;
    logic        i_first_byte = 1'b0;
    logic        i_last_byte = 1'b0;
    logic        i_out_ready = 1'b0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic [2:0]  o_byte_role;
    logic [1:0]  o_error_code;
    logic        o_status_done;
    logic [3:0]  o_ver_major;
    logic [3:0]  o_ver_minor;
    logic [9:0]  o_resp_code;
    logic [15:0] o_reason_length;
    logic        o_header_done;
    logic [15:0] o_name_length;
    logic [15:0] o_value_length;
    logic        o_headers_end;

    http_response_head_parser dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_data_byte     (i_data_byte),
        .i_first_byte    (i_first_byte),
        .i_last_byte     (i_last_byte),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_byte_role     (o_byte_role),
        .o_error_code    (o_error_code),
        .o_status_done   (o_status_done),
        .o_ver_major     (o_ver_major),
        .o_ver_minor     (o_ver_minor),
        .o_resp_code     (o_resp_code),
        .o_reason_length (o_reason_length),
        .o_header_done   (o_header_done),
        .o_name_length   (o_name_length),
        .o_value_length  (o_value_length),
        .o_headers_end   (o_headers_end)
    );

    always #5 i_clk = ~i_clk;

    // Predictor state.
    hrp_pkg::t_phase p_phase;
    logic [2:0]      p_lit;
    logic [9:0]      p_code;
    logic [3:0]      p_major;
    logic [3:0]      p_minor;
    logic [15:0]     p_field;
    logic [15:0]     p_value;
    logic [15:0]     p_trim;
    logic [1:0]      p_err;

    hrp_pkg::t_result pending_tags[$];
    logic [7:0]       msg_buf[$];
    int               fail_count = 0;
    int               bytes_sent = 0;
    bit               idle_on = 1'b1;
    int               stall_left = 0;

    function automatic void clear_parse();
        p_phase = hrp_pkg::PH_LIT;
        p_lit   = 3'd0;
        p_code  = 10'd0;
        p_major = 4'd0;
        p_minor = 4'd0;
        p_field = 16'd0;
        p_value = 16'd0;
        p_trim  = 16'd0;
        p_err   = hrp_pkg::ERR_NONE;
    endfunction

    function automatic logic [15:0] sat_inc(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    function automatic bit is_digit(input logic [7:0] c);
        return c >= hrp_pkg::CH_ZERO && c <= hrp_pkg::CH_NINE;
    endfunction

    function automatic hrp_pkg::t_result parse_byte(input logic [7:0] c, input logic f,
                                                    input logic l);
        hrp_pkg::t_result r;
        bit               bad;
        r = '0;
        bad = 1'b0;
        r.role = hrp_pkg::ROLE_SYNTAX;
        if (f) clear_parse();
        case (p_phase)
            hrp_pkg::PH_LIT: begin
                if (c == PROTO_TEXT[39 - 8 * p_lit -: 8]) begin
                    p_lit = p_lit + 3'd1;
                    if (p_lit == hrp_pkg::LIT_LEN) begin
                        p_phase = hrp_pkg::PH_MAJOR;
                        p_lit = 3'd0;
                    end
                end else bad = 1'b1;
            end
            hrp_pkg::PH_MAJOR: begin
                if (is_digit(c)) begin
                    p_major = 4'(c - hrp_pkg::CH_ZERO);
                    p_phase = hrp_pkg::PH_DOT;
                end else bad = 1'b1;
            end
            hrp_pkg::PH_DOT: begin
                if (c == hrp_pkg::CH_DOT) p_phase = hrp_pkg::PH_MINOR;
                else bad = 1'b1;
            end
            hrp_pkg::PH_MINOR: begin
                if (is_digit(c)) begin
                    p_minor = 4'(c - hrp_pkg::CH_ZERO);
                    p_phase = hrp_pkg::PH_SP1;
                end else bad = 1'b1;
            end
            hrp_pkg::PH_SP1: begin
                if (c == hrp_pkg::CH_SPACE) begin
                    p_phase = hrp_pkg::PH_CODE;
                    p_lit = 3'd0;
                    p_code = 10'd0;
                end else bad = 1'b1;
            end
            hrp_pkg::PH_CODE: begin
                if (is_digit(c)) begin
                    p_code = 10'(p_code * 10 + (c - hrp_pkg::CH_ZERO));
                    p_lit = p_lit + 3'd1;
                    if (p_lit >= 3'(hrp_pkg::CODE_LEN)) begin
                        p_phase = hrp_pkg::PH_SP2;
                        p_lit = 3'd0;
                    end
                end else bad = 1'b1;
            end
            hrp_pkg::PH_SP2: begin
                if (c == hrp_pkg::CH_SPACE) begin
                    p_phase = hrp_pkg::PH_REASON;
                    p_field = 16'd0;
                end else bad = 1'b1;
            end
            hrp_pkg::PH_REASON: begin
                if (c == hrp_pkg::CH_LF) begin
                    r.status_done = 1'b1;
                    r.reason_len = (p_field == 16'd0) ? 16'd0 : p_field - 16'd1;
                    p_phase = hrp_pkg::PH_LINE;
                end else begin
                    r.role = hrp_pkg::ROLE_REASON;
                    p_field = sat_inc(p_field);
                end
            end
            hrp_pkg::PH_LINE: begin
                p_field = 16'd0;
                p_value = 16'd0;
                p_trim = 16'd0;
                if (c == hrp_pkg::CH_CR) p_phase = hrp_pkg::PH_END_LF;
                else if (c == hrp_pkg::CH_COLON) p_phase = hrp_pkg::PH_OWS;
                else begin
                    r.role = hrp_pkg::ROLE_NAME;
                    p_field = 16'd1;
                    p_phase = hrp_pkg::PH_NAME;
                end
            end
            hrp_pkg::PH_NAME: begin
                if (c == hrp_pkg::CH_COLON) p_phase = hrp_pkg::PH_OWS;
                else begin
                    r.role = hrp_pkg::ROLE_NAME;
                    p_field = sat_inc(p_field);
                end
            end
            hrp_pkg::PH_OWS, hrp_pkg::PH_VALUE: begin
                if (c == hrp_pkg::CH_CR) begin
                    p_phase = hrp_pkg::PH_HDR_LF;
                end else if (c == hrp_pkg::CH_SPACE || c == hrp_pkg::CH_TAB) begin
                    if (p_phase == hrp_pkg::PH_VALUE) begin
                        r.role = hrp_pkg::ROLE_VALUE;
                        p_value = sat_inc(p_value);
                    end
                end else if (c < hrp_pkg::CH_SPACE) begin
                    bad = 1'b1;
                end else begin
                    r.role = hrp_pkg::ROLE_VALUE;
                    p_value = sat_inc(p_value);
                    p_trim = p_value;
                    p_phase = hrp_pkg::PH_VALUE;
                end
            end
            hrp_pkg::PH_HDR_LF: begin
                if (c == hrp_pkg::CH_LF) begin
                    r.header_done = 1'b1;
                    r.name_len = p_field;
                    r.value_len = p_trim;
                    p_phase = hrp_pkg::PH_LINE;
                end else bad = 1'b1;
            end
            hrp_pkg::PH_END_LF: begin
                if (c == hrp_pkg::CH_LF) begin
                    r.headers_end = 1'b1;
                    p_phase = hrp_pkg::PH_BODY;
                end else bad = 1'b1;
            end
            hrp_pkg::PH_BODY: r.role = hrp_pkg::ROLE_BODY;
            default: r.role = hrp_pkg::ROLE_IGNORED;
        endcase
        if (bad) begin
            p_err = hrp_pkg::ERR_BAD_BYTE;
            p_phase = hrp_pkg::PH_ERROR;
            r.role = hrp_pkg::ROLE_IGNORED;
        end
        if (l && p_phase != hrp_pkg::PH_BODY && p_phase != hrp_pkg::PH_ERROR) begin
            p_err = hrp_pkg::ERR_TRUNCATED;
            p_phase = hrp_pkg::PH_ERROR;
        end
        r.error = p_err;
        r.major = p_major;
        r.minor = p_minor;
        r.code = p_code;
        return r;
    endfunction

    // Called at a falling edge; returns at the falling edge after the item is taken.
    task automatic send_byte(input logic [7:0] b, input logic f, input logic l);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_data_byte  <= b;
        i_first_byte <= f;
        i_last_byte  <= l;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        pending_tags.push_back(parse_byte(b, f, l));
        bytes_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_buf(input bit with_first, input bit with_last);
        for (int i = 0; i < msg_buf.size(); i++) begin
            send_byte(msg_buf[i], with_first && i == 0, with_last && i == msg_buf.size() - 1);
        end
        msg_buf.delete();
    endtask

    function automatic void put_text(input string s);
        for (int i = 0; i < s.len(); i++) msg_buf.push_back(s[i]);
    endfunction

    function automatic logic [7:0] rand_digit();
        return hrp_pkg::CH_ZERO + 8'($urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] rand_ows();
        return $urandom_range(0, 1) ? hrp_pkg::CH_SPACE : hrp_pkg::CH_TAB;
    endfunction

    function automatic void build_random_message();
        logic [7:0] b;
        msg_buf.delete();
        put_text("HTTP/");
        msg_buf.push_back(rand_digit());
        msg_buf.push_back(hrp_pkg::CH_DOT);
        msg_buf.push_back(rand_digit());
        msg_buf.push_back(hrp_pkg::CH_SPACE);
        repeat (3) msg_buf.push_back(rand_digit());
        msg_buf.push_back(hrp_pkg::CH_SPACE);
        repeat ($urandom_range(0, 6)) begin
            b = 8'($urandom);
            msg_buf.push_back(b == hrp_pkg::CH_LF ? hrp_pkg::CH_CR : b);
        end
        if ($urandom_range(0, 7) != 0) msg_buf.push_back(hrp_pkg::CH_CR);
        msg_buf.push_back(hrp_pkg::CH_LF);
        repeat ($urandom_range(0, 4)) begin
            repeat ($urandom_range(0, 5)) begin
                b = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'h61 + 8'($urandom_range(0, 25));
                msg_buf.push_back(b == hrp_pkg::CH_COLON ? 8'h2D : b);
            end
            msg_buf.push_back(hrp_pkg::CH_COLON);
            repeat ($urandom_range(0, 2)) msg_buf.push_back(rand_ows());
            repeat ($urandom_range(0, 6)) begin
                if ($urandom_range(0, 7) == 0) msg_buf.push_back(rand_ows());
                else msg_buf.push_back(8'($urandom_range(8'h21, 8'hFF)));
            end
            repeat ($urandom_range(0, 2)) msg_buf.push_back(rand_ows());
            msg_buf.push_back(hrp_pkg::CH_CR);
            msg_buf.push_back(hrp_pkg::CH_LF);
        end
        msg_buf.push_back(hrp_pkg::CH_CR);
        msg_buf.push_back(hrp_pkg::CH_LF);
        repeat ($urandom_range(0, 4)) msg_buf.push_back(8'($urandom));
    endfunction

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (pending_tags.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic test_status_line();
        // Starts without a first-byte flag: the parser must already be at the status line.
        put_text("HTTP/1.1 200 OK\015\nContent-Type: text/plain \t\015\n\015\nhi");
        send_buf(1'b0, 1'b1);
        put_text("HTTP/0.0 000 \n\015\n");
        send_buf(1'b1, 1'b1);
        put_text("HTTP/9.9 999 Gone\t\n\015\nz");
        send_buf(1'b1, 1'b1);
    endtask

    task automatic test_header_fields();
        put_text("HTTP/1.0 404 \015\n:\015\nX:\t \015\na\015b\n: v \t\015\n");
        put_text("K:\177\200\377 \015\n\015\n\015\n:");
        send_buf(1'b1, 1'b1);
        // A last-byte flag inside the body leaves later bytes in the body.
        put_text("zz");
        send_buf(1'b0, 1'b0);
    endtask

    task automatic test_error_cases();
        string broken[$] = '{"HTTX", "HTTP/a", "HTTP/1,", "HTTP/1.x", "HTTP/1.1x",
                             "HTTP/1.1 2x0", "HTTP/1.1 20 ", "HTTP/1.1 200x",
                             "HTTP/1.1 200 OK\015\nA:b\n", "HTTP/1.1 200 OK\015\nA:b\015x",
                             "HTTP/1.1 200 OK\015\n\015x", "HTTP/1.1 200 OK\015\nA:\037"};
        foreach (broken[i]) begin
            put_text(broken[i]);
            put_text("ab");
            send_buf(1'b1, 1'b0);
        end
        put_text("HTTP/1.1 200 OK\015\nA:");
        msg_buf.push_back(8'h00);
        put_text("b");
        send_buf(1'b1, 1'b0);
        put_text("HTTP/1.1 2");
        send_buf(1'b1, 1'b1);
        put_text("xy");
        send_buf(1'b0, 1'b0);
        put_text("HTTP/1.1 200 OK\015\nName");
        send_buf(1'b1, 1'b1);
        put_text("HTTP/1.1 200 OK\015\n\015");
        send_buf(1'b1, 1'b1);
        put_text("HTTX");
        send_buf(1'b1, 1'b1);
    endtask

    task automatic test_long_fields();
        put_text("HTTP/1.1 200 ");
        send_buf(1'b1, 1'b0);
        repeat (40) send_byte("r", 1'b0, 1'b0);
        put_text("\015\n");
        send_buf(1'b0, 1'b0);
        repeat (40) send_byte("n", 1'b0, 1'b0);
        send_byte(hrp_pkg::CH_COLON, 1'b0, 1'b0);
        repeat (40) send_byte("v", 1'b0, 1'b0);
        put_text(" \015\n\015\nb");
        send_buf(1'b0, 1'b1);
    endtask

    task automatic test_random_messages(input int target);
        int start;
        int mode;
        int cut;
        start = bytes_sent;
        while (bytes_sent - start < target) begin
            mode = $urandom_range(0, 19);
            if (mode == 0) begin
                repeat ($urandom_range(1, 20)) begin
                    send_byte(8'($urandom), $urandom_range(0, 7) == 0, $urandom_range(0, 7) == 0);
                end
            end else begin
                build_random_message();
                if (mode <= 2) begin
                    msg_buf[$urandom_range(0, msg_buf.size() - 1)] = 8'($urandom);
                end else if (mode <= 4) begin
                    cut = $urandom_range(1, msg_buf.size());
                    while (msg_buf.size() > cut) void'(msg_buf.pop_back());
                end
                send_buf($urandom_range(0, 15) != 0, 1'b1);
            end
        end
    endtask

    always @(negedge i_clk) begin
        if (!idle_on) begin
            stall_left = 0;
            i_out_ready <= 1'b1;
        end else if (stall_left != 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else if ($urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 9) - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    task automatic check_field(input string field, input int unsigned want, input int unsigned got);
        if (want != got) begin
            $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        hrp_pkg::t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_tags.size() == 0) begin
                $display("%0t: result with no item pending, expected none actual role %0d",
                         $time, o_byte_role);
                fail_count++;
            end else begin
                want = pending_tags.pop_front();
                check_field("byte_role", want.role, o_byte_role);
                check_field("error_code", want.error, o_error_code);
                check_field("status_done", want.status_done, o_status_done);
                check_field("ver_major", want.major, o_ver_major);
                check_field("ver_minor", want.minor, o_ver_minor);
                check_field("resp_code", want.code, o_resp_code);
                check_field("reason_length", want.reason_len, o_reason_length);
                check_field("header_done", want.header_done, o_header_done);
                check_field("name_length", want.name_len, o_name_length);
                check_field("value_length", want.value_len, o_value_length);
                check_field("headers_end", want.headers_end, o_headers_end);
            end
        end
    end

    initial begin
        #2ms;
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        clear_parse();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_status_line();
        test_header_fields();
        test_error_cases();
        test_long_fields();
        test_random_messages(140);
        // Let every pending item come out before the closing stretch without idling.
        drain_results();
        idle_on = 1'b0;
        test_random_messages(70);
        i_in_valid <= 1'b0;
        while (pending_tags.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
